// File: rtl/core/gvn_pkg.sv
// shared types, constants and helpers for the grid vertex normal core
package gvn_pkg;

  // grid and storage sizing
  localparam int MAX_GRID_SIDE = 64;
  localparam int STORE_DEPTH   = (MAX_GRID_SIDE + 1) * (MAX_GRID_SIDE + 1);
  localparam int ADDR_W        = $clog2(STORE_DEPTH);
  localparam int SIZE_W        = 7;

  // arithmetic widths
  localparam int COORD_W   = 32;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int SUM_W     = 70;
  localparam int NORM_BITS = 30;
  localparam int WIDE_SH   = 8;
  localparam int LEN2_W    = 2 * NORM_BITS + 2;
  localparam int ROOT_W    = LEN2_W / 2;
  localparam int NRM_W     = 16;
  localparam int FRAC_BITS = 14;
  localparam int NUM_W     = NORM_BITS + FRAC_BITS + 1;
  localparam int QUO_W     = 16;
  localparam int CNT_W     = 6;

  localparam logic [QUO_W-1:0] UNIT_Q14 = QUO_W'(16384);

  // configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_WRITE,
    CMD_READ,
    CMD_MUL,
    CMD_NORM_INIT,
    CMD_NORM_STEP,
    CMD_SQR,
    CMD_SQRT_INIT,
    CMD_SQRT_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_DIV_STORE,
    CMD_OUT_LOAD
  } gvn_cmd_e;

  typedef struct packed {
    gvn_cmd_e         op;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       comp;
    logic             degen;
  } gvn_cmd_t;

  typedef struct packed {
    logic is_query;
    logic in_grid;
    logic norm_zero;
    logic norm_busy;
    logic len_zero;
  } gvn_stat_t;

  // input and result beats
  typedef struct packed {
    logic                      operation;
    logic [SIZE_W-1:0]         row;
    logic [SIZE_W-1:0]         column;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
  } gvn_in_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic                    degenerate;
  } gvn_out_t;

  // odd sizes round up to even, then clamp to the supported range
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [SIZE_W:0] t;
    t = {1'b0, v} + {{SIZE_W{1'b0}}, v[0]};
    if (t < (SIZE_W+1)'(2)) begin
      t = (SIZE_W+1)'(2);
    end
    if (t > (SIZE_W+1)'(MAX_GRID_SIDE)) begin
      t = (SIZE_W+1)'(MAX_GRID_SIDE);
    end
    return t[SIZE_W-1:0];
  endfunction

endpackage

// File: rtl/core/grid_vertex_normals_core.sv
// top level: vertex normal core with position memory and iterative normalizer
// a write beat passes through load and decode; a query reads the neighbors, then runs the
//   multiply phase, the normalizer, a 31-step square root and three divides before its result
// a query outside the grid goes straight to its result; one with a zero-length sum skips sqrt and divides
// throughput: one beat at a time; a new beat is taken while a result waits in the output
// reset: asynchronous active low; sizes return to 64, position memory is not cleared
module grid_vertex_normals_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  gvn_pkg::gvn_in_t           in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output gvn_pkg::gvn_out_t          out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [gvn_pkg::SIZE_W-1:0] cfg_data_i
);

  gvn_pkg::gvn_cmd_t  cmd;
  gvn_pkg::gvn_stat_t stat;

  gvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  gvn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_data_o  (out_data_o)
  );

  // one beat in flight: after an accept the input stalls
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // degenerate results carry a zero normal
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.degenerate |->
      out_data_o.normal_x == '0 && out_data_o.normal_y == '0 && out_data_o.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  // normal components stay within unit range
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.normal_x <= 16'sd16384 && out_data_o.normal_x >= -16'sd16384 &&
      out_data_o.normal_y <= 16'sd16384 && out_data_o.normal_y >= -16'sd16384 &&
      out_data_o.normal_z <= 16'sd16384 && out_data_o.normal_z >= -16'sd16384)
    else $error("normal component out of unit range");

endmodule

// File: rtl/core/gvn_ctrl.sv
// sequencing state machine for writes and normal queries
module gvn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  gvn_pkg::gvn_stat_t stat_i,
  output gvn_pkg::gvn_cmd_t  cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_READ   = 4'd2;
  localparam logic [3:0] S_MUL    = 4'd3;
  localparam logic [3:0] S_NORMI  = 4'd4;
  localparam logic [3:0] S_NORM   = 4'd5;
  localparam logic [3:0] S_SQR    = 4'd6;
  localparam logic [3:0] S_SQRTI  = 4'd7;
  localparam logic [3:0] S_SQRT   = 4'd8;
  localparam logic [3:0] S_LENCHK = 4'd9;
  localparam logic [3:0] S_DIVI   = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_DSTORE = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  // step counts of the multi-cycle phases
  localparam logic [gvn_pkg::CNT_W-1:0] READ_LAST = gvn_pkg::CNT_W'(5);
  localparam logic [gvn_pkg::CNT_W-1:0] MUL_LAST  = gvn_pkg::CNT_W'(32);
  localparam logic [gvn_pkg::CNT_W-1:0] SQR_LAST  = gvn_pkg::CNT_W'(3);
  localparam logic [gvn_pkg::CNT_W-1:0] SQRT_LAST = gvn_pkg::CNT_W'(gvn_pkg::ROOT_W - 1);
  localparam logic [gvn_pkg::CNT_W-1:0] DIV_LAST  = gvn_pkg::CNT_W'(gvn_pkg::QUO_W - 1);
  localparam logic [1:0]                COMP_LAST = 2'd2;

  logic [3:0]                state_q, state_d;
  logic [gvn_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]                comp_q, comp_d;
  logic                      degen_q, degen_d;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // next state and command decode
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    comp_d      = comp_q;
    degen_d     = degen_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.op    = gvn_pkg::CMD_NOP;
    cmd_o.cnt   = cnt_q;
    cmd_o.comp  = comp_q;
    cmd_o.degen = degen_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = gvn_pkg::CMD_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        cnt_d = '0;
        if (!stat_i.is_query) begin
          cmd_o.op = gvn_pkg::CMD_WRITE;
          state_d  = S_IDLE;
        end else if (!stat_i.in_grid) begin
          degen_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.op = gvn_pkg::CMD_READ;
        if (cnt_q == READ_LAST) begin
          cnt_d   = '0;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_MUL: begin
        cmd_o.op = gvn_pkg::CMD_MUL;
        if (cnt_q == MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_NORMI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_NORMI: begin
        cmd_o.op = gvn_pkg::CMD_NORM_INIT;
        state_d  = S_NORM;
      end
      S_NORM: begin
        if (stat_i.norm_zero) begin
          degen_d = 1'b1;
          state_d = S_DONE;
        end else if (!stat_i.norm_busy) begin
          cnt_d   = '0;
          state_d = S_SQR;
        end else begin
          cmd_o.op = gvn_pkg::CMD_NORM_STEP;
        end
      end
      S_SQR: begin
        cmd_o.op = gvn_pkg::CMD_SQR;
        if (cnt_q == SQR_LAST) begin
          cnt_d   = '0;
          state_d = S_SQRTI;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_SQRTI: begin
        cmd_o.op = gvn_pkg::CMD_SQRT_INIT;
        cnt_d    = '0;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.op = gvn_pkg::CMD_SQRT_STEP;
        if (cnt_q == SQRT_LAST) begin
          cnt_d   = '0;
          state_d = S_LENCHK;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LENCHK: begin
        comp_d = '0;
        if (stat_i.len_zero) begin
          degen_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        cmd_o.op = gvn_pkg::CMD_DIV_INIT;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = gvn_pkg::CMD_DIV_STEP;
        if (cnt_q == DIV_LAST) begin
          state_d = S_DSTORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DSTORE: begin
        cmd_o.op = gvn_pkg::CMD_DIV_STORE;
        if (comp_q == COMP_LAST) begin
          degen_d = 1'b0;
          state_d = S_DONE;
        end else begin
          comp_d  = comp_q + 1'b1;
          state_d = S_DIVI;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.op    = gvn_pkg::CMD_OUT_LOAD;
          out_valid_d = 1'b1;
          degen_d     = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      comp_q      <= '0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      comp_q      <= comp_d;
      degen_q     <= degen_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: rtl/core/gvn_dp.sv
// datapath: position memory, cross-product accumulator, normalizer, sqrt and divider
module gvn_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_index_i,
  input  logic [gvn_pkg::SIZE_W-1:0]        cfg_data_i,
  input  gvn_pkg::gvn_in_t                  in_data_i,
  input  gvn_pkg::gvn_cmd_t                 cmd_i,
  output gvn_pkg::gvn_stat_t                stat_o,
  output gvn_pkg::gvn_out_t                 out_data_o
);

  typedef struct packed {
    logic signed [gvn_pkg::EDGE_W-1:0] x;
    logic signed [gvn_pkg::EDGE_W-1:0] y;
    logic signed [gvn_pkg::EDGE_W-1:0] z;
  } edge_t;

  localparam int AW = gvn_pkg::ADDR_W;
  localparam int CW = gvn_pkg::COORD_W;
  localparam int SW = gvn_pkg::SUM_W;

  // configuration
  logic [gvn_pkg::SIZE_W-1:0] gw_q, gh_q, gw, gh, pitch, row, col;

  // item and memory
  gvn_pkg::gvn_in_t   item_q;
  logic [3*CW-1:0]    mem [gvn_pkg::STORE_DEPTH];
  logic [3*CW-1:0]    rd_data_q;
  logic [AW-1:0]      base, rd_addr;
  logic [2*gvn_pkg::SIZE_W-1:0] row_off;
  logic               wr_en;
  logic               have_dn, have_rt, have_up, have_lf, have_slot;
  logic [1:0]         slot_idx;
  logic signed [CW-1:0] q_x, q_y, q_z;

  // cross products
  logic signed [CW-1:0] p_x_q, p_y_q, p_z_q;
  edge_t              e_q [4];
  logic [3:0]         have_q;
  logic signed [gvn_pkg::EDGE_W-1:0] mul_a, mul_b;
  logic signed [gvn_pkg::PROD_W-1:0] prod_q;
  logic signed [SW-1:0] prod_ext;
  logic               tag_v_q;
  logic [2:0]         tag_t_q, term;
  logic signed [SW-1:0] sx_q, sy_q, sz_q;

  // normalize, sqrt, divide
  logic [SW-1:0]      mx_q, my_q, mz_q, or_all;
  logic [2:0]         sgn_q;
  logic [gvn_pkg::NORM_BITS-1:0] sm_sel;
  logic [1:0]         sel_idx;
  logic [gvn_pkg::LEN2_W-1:0] len2_q, src_q;
  logic [gvn_pkg::ROOT_W+1:0] rem_q, sq_r2, sq_trial;
  logic [gvn_pkg::ROOT_W-1:0] root_q;
  logic [gvn_pkg::NUM_W-1:0]  num;
  logic [gvn_pkg::ROOT_W:0]   drem_q, dv_r2;
  logic [gvn_pkg::QUO_W-1:0]  dsrc_q, quo_q, quo_clamp, quo_signed;
  logic signed [gvn_pkg::NRM_W-1:0] nx_q, ny_q, nz_q;
  gvn_pkg::gvn_out_t out_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= gvn_pkg::SIZE_W'(gvn_pkg::MAX_GRID_SIDE);
      gh_q <= gvn_pkg::SIZE_W'(gvn_pkg::MAX_GRID_SIDE);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        gvn_pkg::CFG_GRID_WIDTH:  gw_q <= cfg_data_i;
        gvn_pkg::CFG_GRID_HEIGHT: gh_q <= cfg_data_i;
        default: gw_q <= gw_q;
      endcase
    end
  end

  // addressing and grid bounds
  always_comb begin
    gw      = gvn_pkg::eff_size(gw_q);
    gh      = gvn_pkg::eff_size(gh_q);
    pitch   = gw + 1'b1;
    row     = item_q.row;
    col     = item_q.column;
    row_off = row * pitch;
    base    = AW'(row_off) + AW'(col);
    have_dn = row < gh;
    have_rt = col < gw;
    have_up = row != '0;
    have_lf = col != '0;
    wr_en   = (cmd_i.op == gvn_pkg::CMD_WRITE) && stat_o.in_grid;
    unique case (cmd_i.cnt[2:0])
      3'd1:    rd_addr = have_dn ? base + AW'(pitch) : base;
      3'd2:    rd_addr = have_rt ? base + 1'b1 : base;
      3'd3:    rd_addr = have_up ? base - AW'(pitch) : base;
      3'd4:    rd_addr = have_lf ? base - 1'b1 : base;
      default: rd_addr = base;
    endcase
    slot_idx = 2'(cmd_i.cnt[2:0] - 3'd2);
    unique case (slot_idx)
      2'd0:    have_slot = have_dn;
      2'd1:    have_slot = have_rt;
      2'd2:    have_slot = have_up;
      default: have_slot = have_lf;
    endcase
    q_x = rd_data_q[3*CW-1:2*CW];
    q_y = rd_data_q[2*CW-1:CW];
    q_z = rd_data_q[CW-1:0];
  end

  // position memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[base] <= {item_q.pos_x, item_q.pos_y, item_q.pos_z};
    end
    rd_data_q <= mem[rd_addr];
  end

  // shared multiplier operand selection
  always_comb begin
    term    = cmd_i.cnt[2:0];
    sel_idx = (cmd_i.op == gvn_pkg::CMD_SQR) ? cmd_i.cnt[1:0] : cmd_i.comp;
    unique case (sel_idx)
      2'd0:    sm_sel = mx_q[gvn_pkg::NORM_BITS-1:0];
      2'd1:    sm_sel = my_q[gvn_pkg::NORM_BITS-1:0];
      default: sm_sel = mz_q[gvn_pkg::NORM_BITS-1:0];
    endcase
    mul_a = '0;
    mul_b = '0;
    if (cmd_i.op == gvn_pkg::CMD_MUL) begin
      unique case (term)
        3'd0: begin mul_a = e_q[0].y; mul_b = e_q[1].z; end
        3'd1: begin mul_a = e_q[0].z; mul_b = e_q[1].y; end
        3'd2: begin mul_a = e_q[0].z; mul_b = e_q[1].x; end
        3'd3: begin mul_a = e_q[0].x; mul_b = e_q[1].z; end
        3'd4: begin mul_a = e_q[0].x; mul_b = e_q[1].y; end
        3'd5: begin mul_a = e_q[0].y; mul_b = e_q[1].x; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end else if (cmd_i.op == gvn_pkg::CMD_SQR) begin
      mul_a = gvn_pkg::EDGE_W'(sm_sel);
      mul_b = gvn_pkg::EDGE_W'(sm_sel);
    end
    prod_ext = {{(SW - gvn_pkg::PROD_W){prod_q[gvn_pkg::PROD_W-1]}}, prod_q};
    or_all   = mx_q | my_q | mz_q;
    // sqrt digit step
    sq_r2    = {rem_q[gvn_pkg::ROOT_W-1:0], src_q[gvn_pkg::LEN2_W-1 -: 2]};
    sq_trial = {root_q, 2'b01};
    // divider numerator and restoring step
    num      = gvn_pkg::NUM_W'({sm_sel, {gvn_pkg::FRAC_BITS{1'b0}}})
             + gvn_pkg::NUM_W'(root_q[gvn_pkg::ROOT_W-1:1]);
    dv_r2    = {drem_q[gvn_pkg::ROOT_W-1:0], dsrc_q[gvn_pkg::QUO_W-1]};
    // clamp and apply sign
    quo_clamp  = (quo_q > gvn_pkg::UNIT_Q14) ? gvn_pkg::UNIT_Q14 : quo_q;
    quo_signed = sgn_q[cmd_i.comp] ? (~quo_clamp + 1'b1) : quo_clamp;
  end

  // status to the controller
  always_comb begin
    stat_o.is_query  = item_q.operation;
    stat_o.in_grid   = (row <= gh) && (col <= gw);
    stat_o.norm_zero = (or_all == '0);
    stat_o.norm_busy = |or_all[SW-1:gvn_pkg::NORM_BITS];
    stat_o.len_zero  = (root_q == '0);
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (cmd_i.op)
      gvn_pkg::CMD_LOAD: begin
        item_q <= in_data_i;
      end
      gvn_pkg::CMD_READ: begin
        sx_q <= '0;
        sy_q <= '0;
        sz_q <= '0;
        // capture the word whose address was issued in the previous cycle
        if (cmd_i.cnt[2:0] == 3'd1) begin
          p_x_q <= q_x;
          p_y_q <= q_y;
          p_z_q <= q_z;
        end else if (cmd_i.cnt[2:0] != 3'd0) begin
          e_q[slot_idx].x <= gvn_pkg::EDGE_W'(q_x) - gvn_pkg::EDGE_W'(p_x_q);
          e_q[slot_idx].y <= gvn_pkg::EDGE_W'(q_y) - gvn_pkg::EDGE_W'(p_y_q);
          e_q[slot_idx].z <= gvn_pkg::EDGE_W'(q_z) - gvn_pkg::EDGE_W'(p_z_q);
          have_q[slot_idx] <= have_slot;
        end
      end
      gvn_pkg::CMD_MUL: begin
        tag_v_q <= !cmd_i.cnt[gvn_pkg::CNT_W-1] && (term < 3'd6) && have_q[0] && have_q[1];
        tag_t_q <= term;
        // accumulate the product issued in the previous cycle
        if (tag_v_q && (cmd_i.cnt != '0)) begin
          unique case (tag_t_q[2:1])
            2'd0:    sx_q <= tag_t_q[0] ? sx_q - prod_ext : sx_q + prod_ext;
            2'd1:    sy_q <= tag_t_q[0] ? sy_q - prod_ext : sy_q + prod_ext;
            default: sz_q <= tag_t_q[0] ? sz_q - prod_ext : sz_q + prod_ext;
          endcase
        end
        // rotate to the next neighbor pair
        if ((term == 3'd7) && !cmd_i.cnt[gvn_pkg::CNT_W-1]) begin
          e_q[0] <= e_q[1];
          e_q[1] <= e_q[2];
          e_q[2] <= e_q[3];
          e_q[3] <= e_q[0];
          have_q <= {have_q[0], have_q[3:1]};
        end
      end
      gvn_pkg::CMD_NORM_INIT: begin
        mx_q   <= sx_q[SW-1] ? (~sx_q + 1'b1) : sx_q;
        my_q   <= sy_q[SW-1] ? (~sy_q + 1'b1) : sy_q;
        mz_q   <= sz_q[SW-1] ? (~sz_q + 1'b1) : sz_q;
        sgn_q  <= {sz_q[SW-1], sy_q[SW-1], sx_q[SW-1]};
        len2_q <= '0;
      end
      gvn_pkg::CMD_NORM_STEP: begin
        if (|or_all[SW-1:gvn_pkg::NORM_BITS+gvn_pkg::WIDE_SH-1]) begin
          mx_q <= mx_q >> gvn_pkg::WIDE_SH;
          my_q <= my_q >> gvn_pkg::WIDE_SH;
          mz_q <= mz_q >> gvn_pkg::WIDE_SH;
        end else begin
          mx_q <= mx_q >> 1;
          my_q <= my_q >> 1;
          mz_q <= mz_q >> 1;
        end
      end
      gvn_pkg::CMD_SQR: begin
        if (cmd_i.cnt != '0) begin
          len2_q <= len2_q + prod_q[gvn_pkg::LEN2_W-1:0];
        end
      end
      gvn_pkg::CMD_SQRT_INIT: begin
        rem_q  <= '0;
        root_q <= '0;
        src_q  <= len2_q;
      end
      gvn_pkg::CMD_SQRT_STEP: begin
        src_q <= src_q << 2;
        if (sq_r2 >= sq_trial) begin
          rem_q  <= sq_r2 - sq_trial;
          root_q <= {root_q[gvn_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem_q  <= sq_r2;
          root_q <= {root_q[gvn_pkg::ROOT_W-2:0], 1'b0};
        end
      end
      gvn_pkg::CMD_DIV_INIT: begin
        drem_q <= (gvn_pkg::ROOT_W+1)'(num[gvn_pkg::NUM_W-1:gvn_pkg::QUO_W]);
        dsrc_q <= num[gvn_pkg::QUO_W-1:0];
        quo_q  <= '0;
      end
      gvn_pkg::CMD_DIV_STEP: begin
        dsrc_q <= dsrc_q << 1;
        if (dv_r2 >= {1'b0, root_q}) begin
          drem_q <= dv_r2 - {1'b0, root_q};
          quo_q  <= {quo_q[gvn_pkg::QUO_W-2:0], 1'b1};
        end else begin
          drem_q <= dv_r2;
          quo_q  <= {quo_q[gvn_pkg::QUO_W-2:0], 1'b0};
        end
      end
      gvn_pkg::CMD_DIV_STORE: begin
        unique case (cmd_i.comp)
          2'd0:    nx_q <= quo_signed;
          2'd1:    ny_q <= quo_signed;
          default: nz_q <= quo_signed;
        endcase
      end
      gvn_pkg::CMD_OUT_LOAD: begin
        if (cmd_i.degen) begin
          out_q <= '{normal_x: '0, normal_y: '0, normal_z: '0, degenerate: 1'b1};
        end else begin
          out_q <= '{normal_x: nx_q, normal_y: ny_q, normal_z: nz_q, degenerate: 1'b0};
        end
      end
      default: begin
        tag_v_q <= 1'b0;
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule
